// ----- design/rse_pkg.sv -----
// Shared constants for the randomized set engine: command and status codes,
// field widths and the default capacity. No dependencies.
package rse_pkg;

    // Default number of member slots
    localparam int CAPACITY_DEF = 256;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int VAL_W  = 32;
    localparam int DRAW_W = 16;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 9;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

endpackage

// ----- design/randomized_set_engine.sv -----
// Randomized set engine top level: sequencer, slot search, output register.
// Depends on rse_pkg, rse_slot_mem and rse_mod_unit.
//
//  channel | direction | handshake          | fields
//  --------+-----------+--------------------+-----------------------------------
//  in      | to block  | i_valid / o_stall  | i_cmd, i_value, i_random_draw
//  out     | from block| o_valid / i_stall  | o_status, o_value_out, o_occupancy
//
// Insert and remove scan the occupied slots through the single memory read
// port, one slot a cycle; a remove that hits then reads the last slot and moves it.
// Get random runs the bit-serial remainder unit, then one slot read.
// One item is in work at a time; o_stall is high meanwhile.
// Reset (synchronous, active low) empties the set; slot contents are not cleared.
// A stalled result holds the output register; the next item may be taken meanwhile.
module randomized_set_engine
    import rse_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic signed [VAL_W-1:0]  i_value,
    input  logic [DRAW_W-1:0]        i_random_draw,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [VAL_W-1:0]  o_value_out,
    output logic [OCC_W-1:0]         o_occupancy
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = CW + OCC_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_RDLAST = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_GETRD  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_cmp_v, n_cmp_v;
    logic [AW-1:0]     r_cmp_idx, n_cmp_idx;
    logic [AW-1:0]     r_pos, n_pos;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [STAT_W-1:0] r_res_st, n_res_st;
    logic [VAL_W-1:0]  r_res_val, n_res_val;

    logic              r_out_v, n_out_v;
    logic [STAT_W-1:0] r_out_st, n_out_st;
    logic [VAL_W-1:0]  r_out_val, n_out_val;
    logic [OCC_W-1:0]  r_out_occ, n_out_occ;

    logic              w_accept;
    logic              w_out_free;
    logic              w_match;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [VAL_W-1:0]  w_wr_data;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic [VAL_W-1:0]  w_rd_data;
    logic              w_div_start;
    logic              w_div_done;
    logic [CW-1:0]     w_div_rem;
    logic [CW-1:0]     w_last;
    logic [EW-1:0]     w_count_ext;

    rse_slot_mem #(
        .DEPTH(CAPACITY)
    ) u_slots (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    rse_mod_unit #(
        .CW(CW)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(i_random_draw),
        .i_divisor (r_count),
        .o_done    (w_div_done),
        .o_rem     (w_div_rem)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign w_accept    = i_valid && !o_stall;
    assign w_out_free  = !r_out_v || !i_stall;
    assign w_match     = r_cmp_v && (w_rd_data == r_val);
    assign w_last      = r_count - CW'(1);
    assign w_count_ext = EW'(r_count);

    // Divider loads the draw at the edge that accepts a get-random item on a non-empty set
    assign w_div_start = (r_state == S_IDLE) && w_accept && (i_cmd == CMD_GET)
                         && (r_count != '0);

    // Memory read address selection
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_idx[AW-1:0];
        unique case (r_state)
            S_SEARCH: begin
                w_rd_en   = (r_idx < r_count);
                w_rd_addr = r_idx[AW-1:0];
            end
            S_RDLAST: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_last[AW-1:0];
            end
            S_DIV: begin
                w_rd_en   = w_div_done;
                w_rd_addr = w_div_rem[AW-1:0];
            end
            default: begin
                w_rd_en   = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmp_v   = 1'b0;
        n_cmp_idx = r_idx[AW-1:0];
        n_pos     = r_pos;
        n_cmd     = r_cmd;
        n_val     = r_val;
        n_res_st  = r_res_st;
        n_res_val = r_res_val;
        n_out_v   = r_out_v;
        n_out_st  = r_out_st;
        n_out_val = r_out_val;
        n_out_occ = r_out_occ;
        w_wr_en   = 1'b0;
        w_wr_addr = r_count[AW-1:0];
        w_wr_data = r_val;

        // Output register drains independently
        if (r_out_v && !i_stall) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd     = i_cmd;
                    n_val     = i_value;
                    n_idx     = '0;
                    n_res_st  = ST_REFUSED;
                    n_res_val = '0;
                    priority if (i_cmd == CMD_INSERT || i_cmd == CMD_REMOVE) begin
                        n_state = S_SEARCH;
                    end else if (i_cmd == CMD_GET && r_count != '0) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SEARCH: begin
                // Compare the slot read last cycle while issuing the next read
                n_cmp_v   = (r_idx < r_count);
                n_cmp_idx = r_idx[AW-1:0];
                n_idx     = r_idx + CW'(1);
                if (w_match) begin
                    n_cmp_v = 1'b0;
                    n_pos   = r_cmp_idx;
                    if (r_cmd == CMD_REMOVE) begin
                        n_state = S_RDLAST;
                    end else begin
                        n_res_st = ST_REFUSED;
                        n_state  = S_DONE;
                    end
                end else if (r_idx >= r_count) begin
                    // Scan finished without a hit
                    n_cmp_v = 1'b0;
                    n_state = S_DONE;
                    if (r_cmd == CMD_REMOVE) begin
                        n_res_st = ST_REFUSED;
                    end else if (r_count >= CW'(CAPACITY)) begin
                        n_res_st = ST_FULL;
                    end else begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_count[AW-1:0];
                        w_wr_data = r_val;
                        n_count   = r_count + CW'(1);
                        n_res_st  = ST_DONE;
                    end
                end
            end
            S_RDLAST: begin
                n_state = S_MOVE;
            end
            S_MOVE: begin
                // Last member fills the hole left by the removed one
                w_wr_en   = 1'b1;
                w_wr_addr = r_pos;
                w_wr_data = w_rd_data;
                n_count   = w_last;
                n_res_st  = ST_DONE;
                n_state   = S_DONE;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_GETRD;
                end
            end
            S_GETRD: begin
                n_res_val = w_rd_data;
                n_res_st  = ST_DONE;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_v   = 1'b1;
                    n_out_st  = r_res_st;
                    n_out_val = r_res_val;
                    n_out_occ = w_count_ext[OCC_W-1:0];
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cmp_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cmp_v <= n_cmp_v;
            r_out_v <= n_out_v;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_pos     <= n_pos;
        r_cmd     <= n_cmd;
        r_val     <= n_val;
        r_res_st  <= n_res_st;
        r_res_val <= n_res_val;
        r_out_st  <= n_out_st;
        r_out_val <= n_out_val;
        r_out_occ <= n_out_occ;
    end

    assign o_valid     = r_out_v;
    assign o_status    = r_out_st;
    assign o_value_out = r_out_val;
    assign o_occupancy = r_out_occ;

endmodule

// ----- design/rse_slot_mem.sv -----
// Member slot storage: one write port, one read port, registered read data.
// Depends on rse_pkg for the data width.
module rse_slot_mem
    import rse_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [VAL_W-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [VAL_W-1:0] o_rd_data
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/rse_mod_unit.sv -----
// Bit-serial restoring remainder unit: draw modulo member count,
// one dividend bit per cycle. Depends on rse_pkg for the draw width.
module rse_mod_unit
    import rse_pkg::*;
#(
    parameter int CW = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DRAW_W-1:0] i_dividend,
    input  logic [CW-1:0]     i_divisor,
    output logic              o_done,
    output logic [CW-1:0]     o_rem
);

    localparam int SW = $clog2(DRAW_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [SW-1:0]     r_step, n_step;
    logic [DRAW_W-1:0] r_dvd, n_dvd;
    logic [CW-1:0]     r_div, n_div;
    logic [CW-1:0]     r_rem, n_rem;
    logic [CW:0]       w_trial;
    logic [CW:0]       w_diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_dvd[DRAW_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_dvd  = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[DRAW_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = w_diff[CW-1:0];
            end else begin
                n_rem = w_trial[CW-1:0];
            end
            n_step = r_step + SW'(1);
            if (r_step == SW'(DRAW_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- verif/rse_checker.sv -----
// Checker for the randomized set engine: watches both channels, predicts each result
// from its own copy of the member slots and count, and compares field by field.
// Depends on rse_pkg.
`timescale 1ns / 1ps

module rse_checker
    import rse_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic signed [VAL_W-1:0]  i_value,
    input  logic [DRAW_W-1:0]        i_random_draw,
    // output channel
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic [STAT_W-1:0]        i_status,
    input  logic signed [VAL_W-1:0]  i_value_out,
    input  logic [OCC_W-1:0]         i_occupancy,
    // end of run: anything still expected is a failure
    input  logic                     i_end_check,
    output int                       o_errors,
    output int                       o_pending
);

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [VAL_W-1:0]  value_out;
        logic [OCC_W-1:0]         occupancy;
    } t_set_result;

    // Predicted set contents, packed in slots 0..member_count-1
    logic signed [VAL_W-1:0] member_slots [CAPACITY];
    logic [OCC_W-1:0]        member_count;

    t_set_result results_due [$];
    int          err_count = 0;
    bit          leftover_reported = 1'b0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Apply one command to the predicted set and return the result it gives
    function automatic t_set_result apply_command(input logic [CMD_W-1:0] cmd,
                                                  input logic signed [VAL_W-1:0] value,
                                                  input logic [DRAW_W-1:0] draw);
        t_set_result res;
        int          pos;
        res.status    = ST_REFUSED;
        res.value_out = '0;
        // slot holding the value, or the count when absent
        pos = member_count;
        for (int i = 0; i < member_count; i++) begin
            if (member_slots[i] == value && pos == member_count) pos = i;
        end
        case (cmd)
            CMD_INSERT: begin
                if (pos < member_count) begin
                    res.status = ST_REFUSED;
                end else if (member_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    member_slots[member_count] = value;
                    member_count = member_count + 1'b1;
                    res.status = ST_DONE;
                end
            end
            CMD_REMOVE: begin
                // last member moves into the freed slot
                if (pos < member_count) begin
                    member_count = member_count - 1'b1;
                    member_slots[pos] = member_slots[member_count];
                    res.status = ST_DONE;
                end
            end
            CMD_GET: begin
                if (member_count != 0) begin
                    res.value_out = member_slots[int'(draw) % int'(member_count)];
                    res.status    = ST_DONE;
                end
            end
            default: ;
        endcase
        res.occupancy = member_count;
        return res;
    endfunction

    // Results are checked before the item of the same edge is predicted
    always @(posedge i_clk) begin
        t_set_result due;
        if (!i_rst_n) begin
            member_count = '0;
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    due = results_due.pop_front();
                    if (i_status !== due.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  i_status, due.status));
                    if (i_value_out !== due.value_out)
                        report_mismatch($sformatf("value_out %h, want %h",
                                                  i_value_out, due.value_out));
                    if (i_occupancy !== due.occupancy)
                        report_mismatch($sformatf("occupancy %0d, want %0d",
                                                  i_occupancy, due.occupancy));
                end
            end
            if (i_in_valid && !i_in_stall)
                results_due.push_back(apply_command(i_cmd, i_value, i_random_draw));
            if (i_end_check && !leftover_reported && results_due.size() != 0) begin
                leftover_reported = 1'b1;
                report_mismatch($sformatf("%0d results never arrived", results_due.size()));
            end
        end
        o_errors  <= err_count;
        o_pending <= results_due.size();
    end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the randomized set engine: clock, reset, directed and random
// stimulus, random output stall and the verdict. Depends on rse_pkg,
// randomized_set_engine and rse_checker.
`timescale 1ns / 1ps

module tb_top;
    import rse_pkg::*;

    // Code the block does not use; it must be refused
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int POOL_N = 300;

    typedef enum {PH_FILL, PH_CHURN, PH_DRAIN, PH_SMALL} t_phase;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [CMD_W-1:0]         cmd;
    logic signed [VAL_W-1:0]  in_value;
    logic [DRAW_W-1:0]        draw;
    logic                     out_valid;
    logic                     out_stall;
    logic [STAT_W-1:0]        status;
    logic signed [VAL_W-1:0]  value_out;
    logic [OCC_W-1:0]         occupancy;
    logic                     end_check;
    int                       errors;
    int                       pending;

    // no gaps on either side while set
    bit                       no_idle = 1'b0;
    logic signed [VAL_W-1:0]  value_pool [POOL_N];

    randomized_set_engine u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_cmd         (cmd),
        .i_value       (in_value),
        .i_random_draw (draw),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_status      (status),
        .o_value_out   (value_out),
        .o_occupancy   (occupancy)
    );

    rse_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_cmd         (cmd),
        .i_value       (in_value),
        .i_random_draw (draw),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_status      (status),
        .i_value_out   (value_out),
        .i_occupancy   (occupancy),
        .i_end_check   (end_check),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit on the run
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: a random stall before each result, none in quiet stretches
    initial begin
        int hold;
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 8);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Offer one item after a random gap and wait until it is taken
    task automatic send_item(input logic [CMD_W-1:0] c, input logic signed [VAL_W-1:0] v,
                             input logic [DRAW_W-1:0] d);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        in_value <= v;
        draw     <= d;
        do @(posedge clk); while (in_stall);
    endtask

    // Hold off until every outstanding result has come back or a spin limit is reached
    task automatic wait_all_results();
        int spins;
        spins = 0;
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
            spins++;
        end while (pending != 0 && spins < 20000);
    endtask

    // Mostly members of the pool so that inserts collide and removes hit
    function automatic logic signed [VAL_W-1:0] pick_value(input bit few);
        if (few) return value_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 9) == 0) return $urandom;
        return value_pool[$urandom_range(0, POOL_N - 1)];
    endfunction

    // Random items with a command mix suited to the phase
    task automatic run_phase(input t_phase ph, input int n_items);
        int                       r;
        logic [CMD_W-1:0]         c;
        for (int k = 0; k < n_items; k++) begin
            no_idle = (k % 200) < 30;
            r = $urandom_range(0, 99);
            case (ph)
                PH_FILL:  c = r < 80 ? CMD_INSERT : r < 92 ? CMD_GET :
                              r < 97 ? CMD_REMOVE : CMD_UNUSED;
                PH_CHURN: c = r < 45 ? CMD_INSERT : r < 80 ? CMD_REMOVE :
                              r < 97 ? CMD_GET : CMD_UNUSED;
                PH_DRAIN: c = r < 70 ? CMD_REMOVE : r < 90 ? CMD_GET :
                              r < 98 ? CMD_INSERT : CMD_UNUSED;
                default:  c = r < 35 ? CMD_INSERT : r < 65 ? CMD_REMOVE :
                              r < 97 ? CMD_GET : CMD_UNUSED;
            endcase
            send_item(c, pick_value(ph == PH_SMALL), DRAW_W'($urandom_range(0, 65535)));
        end
        no_idle = 1'b0;
    endtask

    initial begin
        logic signed [VAL_W-1:0] v_min;
        logic signed [VAL_W-1:0] v_max;
        v_min = 32'sh8000_0000;
        v_max = 32'sh7fff_ffff;
        for (int i = 0; i < POOL_N; i++) value_pool[i] = $urandom;
        value_pool[0] = v_min;
        value_pool[1] = v_max;
        value_pool[2] = '0;
        value_pool[3] = -1;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        cmd       <= CMD_INSERT;
        in_value  <= '0;
        draw      <= '0;
        end_check <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty set, extremes, duplicates, absent values, unused code
        send_item(CMD_GET, 32'sd5, 16'd3);
        send_item(CMD_REMOVE, v_max, 16'd0);
        send_item(CMD_UNUSED, v_min, 16'hffff);
        send_item(CMD_INSERT, v_min, 16'd0);
        send_item(CMD_INSERT, v_max, 16'hffff);
        send_item(CMD_INSERT, '0, 16'd0);
        send_item(CMD_INSERT, -1, 16'd0);
        send_item(CMD_INSERT, v_min, 16'd0);
        send_item(CMD_GET, '0, 16'd0);
        send_item(CMD_GET, v_max, 16'hffff);
        send_item(CMD_GET, '0, 16'd1);
        send_item(CMD_REMOVE, v_max, 16'd0);
        send_item(CMD_REMOVE, 32'sd12345, 16'd0);
        send_item(CMD_GET, '0, 16'd2);
        send_item(CMD_REMOVE, -1, 16'd0);
        send_item(CMD_UNUSED, v_max, 16'd7);
        send_item(CMD_REMOVE, v_min, 16'd0);
        send_item(CMD_GET, '0, 16'hffff);
        send_item(CMD_REMOVE, '0, 16'd0);
        send_item(CMD_GET, '0, 16'd9);
        send_item(CMD_INSERT, 32'sh5555_aaaa, 16'haaaa);
        send_item(CMD_GET, -1, 16'h5555);
        send_item(CMD_REMOVE, 32'sh5555_aaaa, 16'd0);
        wait_all_results();

        // Fill to capacity, then churn near full, then drain, then a small set
        run_phase(PH_FILL, 450);
        wait_all_results();
        run_phase(PH_CHURN, 900);
        wait_all_results();
        run_phase(PH_DRAIN, 450);
        run_phase(PH_SMALL, 100);

        wait_all_results();
        repeat (300) @(posedge clk);
        end_check <= 1'b1;
        repeat (3) @(posedge clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
